// ----- sv/sorted_range_window_tracker_macros.svh -----
// ---------------------------------------------------------------------------
// sorted_range_window_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_WINDOW_TRACKER_MACROS_SVH
`define SORTED_RANGE_WINDOW_TRACKER_MACROS_SVH

// same-cycle implication
`define SRWT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SRWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/srwt_pkg.sv -----
// ---------------------------------------------------------------------------
// srwt_pkg
// Types and codes for the sorted range window tracker.
// ---------------------------------------------------------------------------
package srwt_pkg;

  localparam int POS_W = 32;
  localparam int TAG_W = 16;
  localparam int DIST_W = 31;
  localparam int BND_W = 34;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_SHUT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SPAWN   = 3'd1,
    ACT_DESPAWN = 3'd2,
    ACT_FULL    = 3'd3,
    ACT_CLOSED  = 3'd4
  } action_t;

  localparam logic [1:0] CFG_LOAD   = 2'd0;
  localparam logic [1:0] CFG_UNLOAD = 2'd1;
  localparam logic [1:0] CFG_SCENE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROW_HI,
    ST_GROW_LO,
    ST_SPAWN_LO,
    ST_SHR_LO,
    ST_SHR_HI,
    ST_SHUT,
    ST_FINISH
  } state_t;

  // broadcast to every cell during an insert
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  pos;
    logic [TAG_W-1:0]  tag;
  } ins_t;

endpackage

// ----- sv/srwt_cell.sv -----
// ---------------------------------------------------------------------------
// srwt_cell
// One table slot: holds a position and tag, shifts up on a sorted insert.
// ---------------------------------------------------------------------------
module srwt_cell import srwt_pkg::*; (
  input  logic                     clk,
  input  ins_t                     ins,
  input  logic                     occ,
  input  logic                     at_end,
  input  logic                     left_gt,
  input  logic signed [POS_W-1:0]  left_pos,
  input  logic [TAG_W-1:0]         left_tag,
  output logic                     gt,
  output logic signed [POS_W-1:0]  pos,
  output logic [TAG_W-1:0]         tag
);

  // new entry goes after all equal ones, so strictly greater moves up
  assign gt = occ && (pos > $signed(ins.pos));

  always_ff @(posedge clk) begin
    if (ins.en) begin
      if (left_gt) begin
        pos <= left_pos;
        tag <= left_tag;
      end else if (gt || at_end) begin
        pos <= $signed(ins.pos);
        tag <= ins.tag;
      end
    end
  end

endmodule

// ----- sv/sorted_range_window_tracker.sv -----
// ---------------------------------------------------------------------------
// sorted_range_window_tracker
// Sorted table of tagged positions with a spawn window around a center.
// ---------------------------------------------------------------------------
// Add, close: the accepted word goes to the finish state, which issues the result word and returns to idle.
// Update: window growth then shrink steps, one table read per cycle while the output word is free;
//   with the scene flag clear it goes straight to finish. Shutdown despawns every entry of the window.
// One command at a time; results leave through a registered output word.
// Reset (rst, synchronous) empties the table, zeroes both window indices,
//   reopens loading and clears the configuration registers.
module sorted_range_window_tracker import srwt_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic signed [POS_W-1:0]  position,
  input  logic [TAG_W-1:0]         entry_tag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               action,
  output logic [TAG_W-1:0]         entry_tag_res,
  output logic                     last
);

`include "sorted_range_window_tracker_macros.svh"

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [DIST_W-1:0] load_dist, unload_dist;
  logic              scene_att;

  state_t state, state_next;
  logic [CW-1:0] count, count_next, wl, wl_next, wh, wh_next;
  logic [CW-1:0] nl, nl_next, scan, scan_next;
  logic          closed, closed_next;
  logic signed [BND_W-1:0] spawn_lo, spawn_hi, keep_lo, keep_hi;

  logic          pend_valid, pend_valid_next;
  action_t       pend_action, pend_action_next;
  logic [TAG_W-1:0] pend_tag, pend_tag_next;
  logic          out_valid_next, last_next;
  action_t       out_action, out_action_next;
  logic [TAG_W-1:0] out_tag, out_tag_next;

  logic in_accept, out_free, ev;
  action_t ev_action;
  ins_t ins;

  logic signed [POS_W-1:0] cpos [MAX_ENTRIES];
  logic [TAG_W-1:0]        ctag [MAX_ENTRIES];
  logic                    cgt  [MAX_ENTRIES];

  logic [CW-1:0]           rd_idx;
  logic signed [POS_W-1:0] rd_pos;
  logic signed [BND_W-1:0] rd_pos_x;
  logic [TAG_W-1:0]        rd_tag;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign ins.en  = in_accept && (cmd_t'(command) == CMD_ADD) && !closed &&
                   (count < CW'(MAX_ENTRIES));
  assign ins.pos = position;
  assign ins.tag = entry_tag;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      srwt_cell u_cell (
        .clk(clk), .ins(ins), .occ(CW'(i) < count), .at_end(CW'(i) == count),
        .left_gt(1'b0), .left_pos(cpos[0]), .left_tag(ctag[0]),
        .gt(cgt[i]), .pos(cpos[i]), .tag(ctag[i])
      );
    end else begin : g_rest
      srwt_cell u_cell (
        .clk(clk), .ins(ins), .occ(CW'(i) < count), .at_end(CW'(i) == count),
        .left_gt(cgt[i-1]), .left_pos(cpos[i-1]), .left_tag(ctag[i-1]),
        .gt(cgt[i]), .pos(cpos[i]), .tag(ctag[i])
      );
    end
  end

  // single table read port, index picked by the current scan step
  always_comb begin
    case (state)
      ST_GROW_HI:          rd_idx = wh;
      ST_GROW_LO:          rd_idx = nl - CW'(1);
      ST_SPAWN_LO, ST_SHUT: rd_idx = scan;
      ST_SHR_LO:           rd_idx = wl;
      ST_SHR_HI:           rd_idx = wh - CW'(1);
      default:             rd_idx = '0;
    endcase
  end

  assign rd_pos   = cpos[rd_idx[AW-1:0]];
  assign rd_tag   = ctag[rd_idx[AW-1:0]];
  assign rd_pos_x = BND_W'(rd_pos);

  always_comb begin
    state_next       = state;
    count_next       = count;
    wl_next          = wl;
    wh_next          = wh;
    nl_next          = nl;
    scan_next        = scan;
    closed_next      = closed;
    pend_valid_next  = pend_valid;
    pend_action_next = pend_action;
    pend_tag_next    = pend_tag;
    out_valid_next   = out_valid && !out_ready;
    out_action_next  = out_action;
    out_tag_next     = out_tag;
    last_next        = last;
    ev               = 1'b0;
    ev_action        = ACT_SPAWN;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_FINISH;
          case (cmd_t'(command))
            CMD_ADD: begin
              if (closed) begin
                pend_valid_next  = 1'b1;
                pend_action_next = ACT_CLOSED;
                pend_tag_next    = '0;
              end else if (count >= CW'(MAX_ENTRIES)) begin
                pend_valid_next  = 1'b1;
                pend_action_next = ACT_FULL;
                pend_tag_next    = '0;
              end else begin
                count_next = count + CW'(1);
              end
            end
            CMD_CLOSE: begin
              closed_next = 1'b1;
              wl_next     = '0;
              wh_next     = '0;
            end
            CMD_UPDATE: begin
              if (scene_att) state_next = ST_GROW_HI;
            end
            CMD_SHUT: begin
              scan_next  = wl;
              state_next = ST_SHUT;
            end
            default: ;
          endcase
        end
      end
      ST_GROW_HI: if (out_free) begin
        if (wh < count && rd_pos_x <= spawn_hi) begin
          ev      = 1'b1;
          wh_next = wh + CW'(1);
        end else begin
          nl_next    = wl;
          state_next = ST_GROW_LO;
        end
      end
      ST_GROW_LO: if (out_free) begin
        if (nl != '0 && rd_pos_x >= spawn_lo) begin
          nl_next = nl - CW'(1);
        end else begin
          scan_next  = nl;
          state_next = ST_SPAWN_LO;
        end
      end
      ST_SPAWN_LO: if (out_free) begin
        if (scan < wl) begin
          ev        = 1'b1;
          scan_next = scan + CW'(1);
        end else begin
          wl_next    = nl;
          state_next = ST_SHR_LO;
        end
      end
      ST_SHR_LO: if (out_free) begin
        if (wl < wh && rd_pos_x < keep_lo) begin
          ev        = 1'b1;
          ev_action = ACT_DESPAWN;
          wl_next   = wl + CW'(1);
        end else begin
          state_next = ST_SHR_HI;
        end
      end
      ST_SHR_HI: if (out_free) begin
        if (wh > wl && rd_pos_x > keep_hi) begin
          ev        = 1'b1;
          ev_action = ACT_DESPAWN;
          wh_next   = wh - CW'(1);
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SHUT: if (out_free) begin
        if (scan < wh) begin
          ev        = 1'b1;
          ev_action = ACT_DESPAWN;
          scan_next = scan + CW'(1);
        end else begin
          wl_next    = '0;
          wh_next    = '0;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: if (out_free) begin
        out_valid_next  = 1'b1;
        last_next       = 1'b1;
        out_action_next = pend_valid ? pend_action : ACT_NONE;
        out_tag_next    = pend_valid ? pend_tag : '0;
        pend_valid_next = 1'b0;
        state_next      = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // an event is held back one step so the final word can carry last
    if (ev) begin
      if (pend_valid) begin
        out_valid_next  = 1'b1;
        last_next       = 1'b0;
        out_action_next = pend_action;
        out_tag_next    = pend_tag;
      end
      pend_valid_next  = 1'b1;
      pend_action_next = ev_action;
      pend_tag_next    = rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      wl          <= '0;
      wh          <= '0;
      nl          <= '0;
      scan        <= '0;
      closed      <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      load_dist   <= '0;
      unload_dist <= '0;
      scene_att   <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      wl         <= wl_next;
      wh         <= wh_next;
      nl         <= nl_next;
      scan       <= scan_next;
      closed     <= closed_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOAD:   load_dist   <= cfg_data[DIST_W-1:0];
          CFG_UNLOAD: unload_dist <= cfg_data[DIST_W-1:0];
          CFG_SCENE:  scene_att   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_action <= pend_action_next;
    pend_tag    <= pend_tag_next;
    out_action  <= out_action_next;
    out_tag     <= out_tag_next;
    last        <= last_next;
    if (in_accept) begin
      spawn_lo <= BND_W'(position) - BND_W'(load_dist);
      spawn_hi <= BND_W'(position) + BND_W'(load_dist);
      keep_lo  <= BND_W'(position) - BND_W'(unload_dist);
      keep_hi  <= BND_W'(position) + BND_W'(unload_dist);
    end
  end

  assign action        = out_action;
  assign entry_tag_res = out_tag;

  `SRWT_ASSERT(a_window_order, 1'b1, wl <= wh, "window low above window high")
  `SRWT_ASSERT(a_window_in_table, 1'b1, wh <= count, "window beyond table fill")
  `SRWT_ASSERT(a_idle_no_pend, state == ST_IDLE, !pend_valid, "held event left at idle")
  `SRWT_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready, "accepted word did not start")

endmodule

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted range window tracker: a directed table
// then random add, close, update and shutdown words, each checked result by
// result against a behavioral predictor of the sorted table and its window.
// ---------------------------------------------------------------------------
module testbench;
  import srwt_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int DRAIN_CYCLES = 3 * TABLE_DEPTH + 12;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    action_t     act;
    logic [15:0] tag;
    logic        last;
  } event_t;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  code;   // command or register index
    logic [31:0] data;   // position or register value
    logic [15:0] tag;
    bit          typed;
    action_t     act;
  } row_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_LOAD;
  logic [31:0]       cfg_data = '0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        command = CMD_ADD;
  logic signed [31:0] position = '0;
  logic [15:0]       entry_tag = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [2:0]        action;
  logic [15:0]       entry_tag_res;
  logic              last;

  sorted_range_window_tracker DUT (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [31:0] pos_q [TABLE_DEPTH];
  logic [15:0]        tag_q [TABLE_DEPTH];
  int                 entry_cnt, win_lo, win_hi;
  bit                 closed;
  longint             load_dist, unload_dist;
  bit                 scene_on;

  event_t pending_events[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  logic [7:0] rx_cnt = 0;

  task automatic note(action_t a, logic [15:0] t);
    event_t e;
    e.act = a;
    e.tag = t;
    e.last = 0;
    pending_events = {pending_events, e};
  endtask

  task automatic predict_window(logic [1:0] cmd, logic signed [31:0] pos, logic [15:0] tag);
    int start, at, nl;
    longint c;
    start = pending_events.size();
    c = pos;
    case (cmd)
      CMD_ADD: begin
        if (closed) note(ACT_CLOSED, '0);
        else if (entry_cnt >= TABLE_DEPTH) note(ACT_FULL, '0);
        else begin
          at = 0;
          while (at < entry_cnt && pos_q[at] <= pos) at++;
          for (int i = entry_cnt; i > at; i--) begin
            pos_q[i] = pos_q[i-1];
            tag_q[i] = tag_q[i-1];
          end
          pos_q[at] = pos;
          tag_q[at] = tag;
          entry_cnt++;
        end
      end
      CMD_CLOSE: begin
        closed = 1;
        win_lo = 0;
        win_hi = 0;
      end
      CMD_UPDATE: if (scene_on) begin
        while (win_hi < entry_cnt && longint'(pos_q[win_hi]) <= c + load_dist) begin
          note(ACT_SPAWN, tag_q[win_hi]);
          win_hi++;
        end
        nl = win_lo;
        while (nl > 0 && longint'(pos_q[nl-1]) >= c - load_dist) nl--;
        for (int i = nl; i < win_lo; i++) note(ACT_SPAWN, tag_q[i]);
        win_lo = nl;
        while (win_lo < win_hi && longint'(pos_q[win_lo]) < c - unload_dist) begin
          note(ACT_DESPAWN, tag_q[win_lo]);
          win_lo++;
        end
        while (win_hi > win_lo && longint'(pos_q[win_hi-1]) > c + unload_dist) begin
          win_hi--;
          note(ACT_DESPAWN, tag_q[win_hi]);
        end
      end
      default: begin
        for (int i = win_lo; i < win_hi; i++) note(ACT_DESPAWN, tag_q[i]);
        win_lo = 0;
        win_hi = 0;
      end
    endcase
    if (pending_events.size() == start) note(ACT_NONE, '0);
    pending_events[pending_events.size()-1].last = 1;
  endtask

  task automatic send_word(logic [1:0] cmd, logic [31:0] pos, logic [15:0] tag,
                           bit typed = 0, action_t act = ACT_NONE);
    bit ok;
    event_t e;
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1;
    command <= cmd;
    position <= pos;
    entry_tag <= tag;
    do begin
      @(negedge clk);
      ok = in_ready;
      if (ok) begin
        predict_window(cmd, pos, tag);
        if (typed) begin
          // directed row: the typed word replaces the predicted one
          e.act = act;
          e.tag = '0;
          e.last = 1;
          pending_events[pending_events.size()-1] = e;
        end
      end
      @(posedge clk);
    end while (!ok);
  endtask

  // let the block go idle before touching a register
  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    bit ok;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      if (ok) begin
        case (idx)
          CFG_LOAD:   load_dist = val[30:0];
          CFG_UNLOAD: unload_dist = val[30:0];
          CFG_SCENE:  scene_on = val[0];
          default: ;
        endcase
      end
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] near_pos();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 400000)) - 200000);
  endfunction

  // receiver stall pattern: mode picked by the top two bits of a free-running counter
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 8'd1;
    case (rx_cnt[7:6])
      2'd0: out_ready <= 1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_cnt[2:0] != 0);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(negedge clk) begin
    event_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_range_window_tracker: mismatch");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: action %0d tag %h last %b", action, entry_tag_res, last);
        end else begin
          e = pending_events.pop_front();
          if (action !== e.act || entry_tag_res !== e.tag || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: exp action %0d tag %h last %b, got %0d %h %b",
                       e.act, e.tag, e.last, action, entry_tag_res, last);
          end
        end
      end
    end
  end

  row_t directed[] = '{
    '{ROW_CFG, CFG_SCENE, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'd0, 16'h0, 1, ACT_NONE},
    '{ROW_CMD, CMD_SHUT, 32'd0, 16'h0, 1, ACT_NONE},
    '{ROW_CMD, CMD_ADD, 32'h8000_0000, 16'hFFFF, 1, ACT_NONE},
    '{ROW_CMD, CMD_ADD, 32'h7FFF_FFFF, 16'h0000, 1, ACT_NONE},
    '{ROW_CMD, CMD_ADD, 32'd0, 16'h0001, 1, ACT_NONE},
    '{ROW_CMD, CMD_ADD, 32'd0, 16'h0002, 1, ACT_NONE},
    '{ROW_CMD, CMD_ADD, 32'd100, 16'h8000, 1, ACT_NONE},
    '{ROW_CFG, CFG_LOAD, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_UNLOAD, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_SCENE, 32'd1, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_ADD, -32'sd5, 16'h0003, 1, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'd100, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, -32'sd5, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_LOAD, 32'hFFFF_FFFF, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_UNLOAD, 32'h7FFF_FFFF, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'h8000_0000, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'h7FFF_FFFF, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_SHUT, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_LOAD, 32'd10, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_UNLOAD, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'd95, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_SHUT, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CFG, CFG_SCENE, 32'd0, 16'h0, 0, ACT_NONE},
    '{ROW_CMD, CMD_UPDATE, 32'd0, 16'h0, 1, ACT_NONE}
  };

  initial begin
    int pick;
    entry_cnt = 0; win_lo = 0; win_hi = 0; closed = 0;
    load_dist = 0; unload_dist = 0; scene_on = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed[i].code, directed[i].data);
      end else begin
        send_word(directed[i].code, directed[i].data, directed[i].tag,
                  directed[i].typed, directed[i].act);
      end
    end

    // loading: fill the table past full, with a few updates on the open table
    drain();
    write_reg(CFG_LOAD, $urandom_range(0, 150000));
    write_reg(CFG_UNLOAD, $urandom_range(0, 150000));
    write_reg(CFG_SCENE, 32'd1 | ($urandom & 32'hFFFF_FFFE));
    for (int n = 0; n < 36; n++) begin
      if ($urandom_range(0, 4) == 0) send_word(CMD_UPDATE, near_pos(), $urandom);
      else send_word(CMD_ADD, near_pos(), $urandom);
    end
    send_word(CMD_CLOSE, $urandom, $urandom);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_LOAD, 32'h7FFF_FFFF);
          write_reg(CFG_UNLOAD, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_LOAD, 32'd0);
          write_reg(CFG_UNLOAD, 32'h8000_0000);
        end
        default: begin
          write_reg(CFG_LOAD, $urandom_range(0, 150000) | ($urandom & 32'h8000_0000));
          write_reg(CFG_UNLOAD, $urandom_range(0, 150000));
        end
      endcase
      write_reg(CFG_SCENE, (ph == 5) ? 32'd0 : 32'd1);
      for (int n = 0; n < 10; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) send_word(CMD_UPDATE, near_pos(), $urandom);
        else if (pick < 84) send_word(CMD_SHUT, $urandom, $urandom);
        else if (pick < 92) send_word(CMD_CLOSE, $urandom, $urandom);
        else send_word(CMD_ADD, near_pos(), $urandom);
      end
    end

    drain();
    if (mismatches == 0 && pending_events.size() == 0)
      $display("sorted_range_window_tracker: match");
    else
      $display("sorted_range_window_tracker: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/srwt_pkg.sv
sv/srwt_cell.sv
sv/sorted_range_window_tracker.sv
dv/testbench.sv
